// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, request/status codes and slot arithmetic for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_READ       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] ERR_VALUE = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value_in;
    logic [3:0]               position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [1:0]               status;
    logic [4:0]               count_out;
    logic                     is_empty;
  } rsp_t;

  // RAM access issued when a request is taken
  typedef struct packed {
    logic                     we;
    logic                     re;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] wdata;
  } ram_cmd_t;

  // Result fields settled at issue; value comes from RAM when use_ram is set
  typedef struct packed {
    logic                     use_ram;
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic                     empty;
  } meta_t;

  // (a + b) mod DEPTH, both operands below DEPTH
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Single-port synchronous RAM, registered read data, q holds while read enable is low.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q <= mem[addr];
    end
  end

endmodule

// File: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front pointer and entry count; decodes a request into a RAM access and
// the result fields known at issue.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  bdq_pkg::req_t         req,
  output bdq_pkg::ram_cmd_t     cmd,
  output bdq_pkg::meta_t        meta,
  output logic [bdq_pkg::CNT_W-1:0] cnt
);
  import bdq_pkg::*;

  logic [ADDR_W-1:0] front;
  logic [ADDR_W-1:0] front_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              full;
  logic              empty;

  always_comb begin
    full       = (cnt == CNT_W'(DEPTH));
    empty      = (cnt == '0);
    front_next = front;
    cnt_next   = cnt;
    cmd        = '{we: 1'b0, re: 1'b0, addr: front, wdata: req.value_in};
    meta       = '{use_ram: 1'b0, value: '0, status: ST_OK, count: '0, empty: 1'b0};

    case (req.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          meta.status = ST_FULL;
        end else begin
          front_next = slot_add(front, ADDR_W'(DEPTH - 1));
          cmd.we     = 1'b1;
          cmd.addr   = front_next;
          cnt_next   = cnt + CNT_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          meta.status = ST_FULL;
        end else begin
          cmd.we   = 1'b1;
          cmd.addr = slot_add(front, cnt[ADDR_W-1:0]);
          cnt_next = cnt + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          meta.value  = ERR_VALUE;
          meta.status = ST_EMPTY;
        end else begin
          cmd.re       = 1'b1;
          meta.use_ram = 1'b1;
          front_next   = slot_add(front, ADDR_W'(1));
          cnt_next     = cnt - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          meta.value  = ERR_VALUE;
          meta.status = ST_EMPTY;
        end else begin
          cnt_next     = cnt - CNT_W'(1);
          cmd.re       = 1'b1;
          cmd.addr     = slot_add(front, cnt_next[ADDR_W-1:0]);
          meta.use_ram = 1'b1;
        end
      end
      REQ_READ: begin
        if (32'(req.position) >= 32'(cnt)) begin
          meta.value  = ERR_VALUE;
          meta.status = ST_EMPTY;
        end else begin
          cmd.re       = 1'b1;
          cmd.addr     = slot_add(front, ADDR_W'(req.position));
          meta.use_ram = 1'b1;
        end
      end
      default: begin
        // unknown request: no change
      end
    endcase

    meta.count = cnt_next;
    meta.empty = (cnt_next == '0);
    // only touch the RAM for a request actually taken
    cmd.we = cmd.we & take;
    cmd.re = cmd.re & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
    end else if (take) begin
      front <= front_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: rtl/bounded_deque_with_indexed_read_top.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_top
// Bounded double-ended queue of signed 32-bit values with indexed read.
// ----------------------------------------------------------------------------
// Each request (push front/back, pop front/back, read at position) returns one
// response carrying the value, status, entry count and empty flag. Entries live
// in a ring buffer of DEPTH words in a single-port RAM. When a request is taken
// the RAM is addressed and the front pointer and count are updated; once the
// output register is free, the registered RAM read returns into the response
// register. One request is in flight at a time; a new request is taken while
// a finished response still waits in the output register. Pushes onto a full
// queue are dropped with a full status; pops on an empty queue and out-of-range
// reads return 0x7FFFFFFF with an empty status.
module bounded_deque_with_indexed_read_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bdq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bdq_pkg::rsp_t  rsp
);
  import bdq_pkg::*;

  ram_cmd_t          cmd;
  meta_t             meta;
  meta_t             pend_meta;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] ram_q;
  logic              pend;
  logic              take;
  logic              move;

  assign req_ready = !pend;
  assign take      = req_valid && req_ready;
  assign move      = pend && (!rsp_valid || rsp_ready);

  bdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (req),
    .cmd  (cmd),
    .meta (meta),
    .cnt  (cnt)
  );

  bdq_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .re    (cmd.re),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .q     (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_meta <= meta;
    end
    if (move) begin
      rsp.value_out <= pend_meta.use_ram ? $signed(ram_q) : pend_meta.value;
      rsp.status    <= pend_meta.status;
      rsp.count_out <= 5'(pend_meta.count);
      rsp.is_empty  <= pend_meta.empty;
    end
  end

  // count stays within capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // a pending request leaves as soon as the output register can take it
  a_pend_drain: assert property (@(posedge clk) disable iff (rst)
    pend && (!rsp_valid || rsp_ready) |=> !pend)
    else $error("pending request not moved to output");

  // an accepted push onto a non-full queue grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    take && (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_BACK)
      && cnt != CNT_W'(DEPTH)
    |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("push did not grow the queue");

  // empty flag agrees with count in the response
  a_rsp_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.count_out == 5'd0)))
    else $error("empty flag disagrees with count");

endmodule

// File: verif/bounded_deque_with_indexed_read_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_checker
// Watches both channels of the deque, predicts each response and compares it.
// ----------------------------------------------------------------------------
// Every accepted request is applied to a local copy of the ring buffer, front
// slot and fill level; the resulting response joins a FIFO of pending
// responses. Every accepted response is checked field by field against the
// oldest pending one. Failures are counted and handed to the testbench top.
module bounded_deque_with_indexed_read_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  bdq_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  bdq_pkg::rsp_t rsp,
  output int            mismatches,
  output int            awaited
);
  import bdq_pkg::*;

  logic signed [DATA_W-1:0] slot_value [DEPTH];
  int   head_slot;
  int   fill;
  rsp_t pending_rsp [$];

  // apply one request to the local deque and return the response it causes
  function automatic rsp_t deque_apply(input req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_OK;
    case (r.req_type)
      REQ_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slot_value[head_slot] = r.value_in;
          fill++;
        end
      end
      REQ_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot_value[(head_slot + fill) % DEPTH] = r.value_in;
          fill++;
        end
      end
      REQ_POP_FRONT: begin
        if (fill == 0) begin
          o.value_out = ERR_VALUE;
          o.status    = ST_EMPTY;
        end else begin
          o.value_out = slot_value[head_slot];
          head_slot   = (head_slot + 1) % DEPTH;
          fill--;
        end
      end
      REQ_POP_BACK: begin
        if (fill == 0) begin
          o.value_out = ERR_VALUE;
          o.status    = ST_EMPTY;
        end else begin
          o.value_out = slot_value[(head_slot + fill - 1) % DEPTH];
          fill--;
        end
      end
      REQ_READ: begin
        if (int'(r.position) >= fill) begin
          o.value_out = ERR_VALUE;
          o.status    = ST_EMPTY;
        end else begin
          o.value_out = slot_value[(head_slot + int'(r.position)) % DEPTH];
        end
      end
      default: ; // undefined request codes leave the deque alone
    endcase
    o.count_out = 5'(fill);
    o.is_empty  = (fill == 0);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      head_slot  = 0;
      fill       = 0;
      mismatches = 0;
      pending_rsp.delete();
    end else begin
      // responses trail their request, so check first
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected response: expected none, got value_out %0d status %0d",
                   $time, rsp.value_out, rsp.status);
          mismatches++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.value_out !== want.value_out) begin
            $display("%0t: value_out expected %0d got %0d",
                     $time, want.value_out, rsp.value_out);
            mismatches++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
            mismatches++;
          end
          if (rsp.count_out !== want.count_out) begin
            $display("%0t: count_out expected %0d got %0d",
                     $time, want.count_out, rsp.count_out);
            mismatches++;
          end
          if (rsp.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0b got %0b",
                     $time, want.is_empty, rsp.is_empty);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) begin
        pending_rsp.push_back(deque_apply(req));
      end
    end
    awaited = pending_rsp.size();
  end

endmodule

// File: verif/bounded_deque_with_indexed_read_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_top_tb
// Stimulus and verdict for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
// A short directed run covers empty pops and reads, undefined request codes,
// extreme values, filling to capacity, pushes onto a full deque, pops from
// both ends and reads at the back end. Random bursts that lean towards filling,
// draining or a mix then follow, in three phases of sender and receiver idling.
// The checker module does all prediction and comparison.
module bounded_deque_with_indexed_read_top_tb;
  import bdq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int mismatches;
  int awaited;
  int cycle_count;
  int send_idle_pct = 25;
  int recv_idle_pct = 49;
  int burst_left    = 0;
  int burst_kind    = 0;

  bounded_deque_with_indexed_read_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bounded_deque_with_indexed_read_checker deque_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // present one request, idling beforehand at random, and hold until taken
  task automatic send_item(input logic [2:0] kind, input logic signed [DATA_W-1:0] value,
                           input logic [3:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{req_type: kind, value_in: value, position: pos};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return ERR_VALUE;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int n);
    logic [2:0] kind;
    int         roll;
    int         push_pct;
    int         pop_pct;
    int         read_pct;
    for (int i = 0; i < n; i++) begin
      // bursts that lean one way drive the deque to full and back to empty
      if (burst_left == 0) begin
        burst_kind = $urandom_range(2);
        burst_left = $urandom_range(40, 8);
      end
      burst_left--;
      case (burst_kind)
        0:       begin push_pct = 70; pop_pct = 12; read_pct = 15; end
        1:       begin push_pct = 12; pop_pct = 70; read_pct = 15; end
        default: begin push_pct = 35; pop_pct = 35; read_pct = 24; end
      endcase
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        kind = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      end else if (roll < push_pct + pop_pct) begin
        kind = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
      end else if (roll < push_pct + pop_pct + read_pct) begin
        kind = REQ_READ;
      end else begin
        kind = REQ_READ + 3'($urandom_range(3, 1));
      end
      send_item(kind, pick_value(), 4'($urandom_range(15)));
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // empty deque and undefined codes
    send_item(REQ_POP_FRONT, 32'sd5, 4'd0);
    send_item(REQ_POP_BACK, 32'sd6, 4'd0);
    send_item(REQ_READ, 32'sd0, 4'd0);
    send_item(REQ_READ + 3'd1, 32'sd7, 4'd3);
    send_item(REQ_READ + 3'd3, -32'sd1, 4'd15);
    // fill to capacity from both ends, extremes first
    for (int i = 0; i < DEPTH; i++) begin
      logic signed [DATA_W-1:0] v;
      case (i)
        0:       v = ERR_VALUE;
        1:       v = 32'sh8000_0000;
        2:       v = -32'sd1;
        3:       v = 32'sd0;
        default: v = $urandom;
      endcase
      send_item(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, v, 4'd15);
    end
    send_item(REQ_PUSH_FRONT, 32'sd11, 4'd0);
    send_item(REQ_PUSH_BACK, 32'sd12, 4'd0);
    send_item(REQ_READ, 32'sd0, 4'd15);
    send_item(REQ_POP_FRONT, 32'sd0, 4'd0);
    send_item(REQ_POP_BACK, 32'sd0, 4'd0);
    send_item(REQ_READ, 32'sd0, 4'd15);

    run_random(530);
    send_idle_pct = 49;
    recv_idle_pct = 25;
    run_random(530);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(540);

    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
